[rtl/core/tzmf_pkg.sv]
// shared types and constants for the zone-gated median filter
// no dependencies; imported by every module under rtl/core
`timescale 1ns / 1ps

package tzmf_pkg;

  localparam int unsigned TARGETS_PER_ZONE = 4;
  localparam int unsigned ZONE_COUNT       = 64;
  localparam int unsigned SENSOR_COUNT     = 2;

  localparam int unsigned HIST_DEPTH       = 3;
  localparam int unsigned SLOTS_PER_SENSOR = ZONE_COUNT * TARGETS_PER_ZONE;
  localparam int unsigned ROWS             = SENSOR_COUNT * SLOTS_PER_SENSOR;
  localparam int unsigned ROW_W            = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned SENSOR_W         = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

  localparam int unsigned QUEUE_DEPTH      = 4;

  localparam logic [7:0] STATUS_RANGE_OK   = 8'd5;
  localparam logic [7:0] STATUS_RANGE_WIDE = 8'd9;

  localparam int unsigned S_TDATA_W = 56;
  localparam int unsigned M_TDATA_W = 48;

  typedef struct packed {
    logic              sensor_sel;
    logic [5:0]        zone;
    logic [1:0]        target_slot;
    logic [2:0]        targets_found;
    logic [7:0]        status_code;
    logic signed [15:0] range_mm;
    logic [15:0]       sigma_mm;
    logic              frame_last;
  } item_t;

  // one classified request, as queued between front and back
  typedef struct packed {
    logic              in_range;
    logic [ROW_W-1:0]  row;
    logic [1:0]        col;
    logic [15:0]       wval;
    logic [15:0]       sigma;
    logic [7:0]        status;
    logic [2:0]        found;
    logic              last;
  } op_t;

  typedef struct packed {
    logic signed [15:0] filtered_distance;
    logic [15:0]        gated_sigma;
    logic [7:0]         gated_status;
    logic [2:0]         targets_out;
    logic               last_of_frame;
  } result_t;

endpackage

[rtl/core/tof_zone_gated_median_filter.sv]
// top level of the zone-gated three-frame median filter
// uses tzmf_pkg, tzmf_front, tzmf_queue, tzmf_back
//
// channel  dir  handshake         payload
// s_*      in   s_tvalid/s_tready tdata: slot fields, tuser: sensor, tlast: frame end
// m_*      out  m_tvalid/m_tready tdata: filtered result, tlast: frame end
//
// one item per cycle sustained while the output does not stall; an accepted item is queued, then
// its history row is read into a register, then the output register loads and raises m_tvalid.
// after reset the history memory is cleared one row a cycle (512 rows) with
// s_tready low. a four-deep queue lets input continue while the output stalls.
`timescale 1ns / 1ps

module tof_zone_gated_median_filter
  import tzmf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // zone, target_slot, targets_found, status_code, range_mm, sigma_mm
  input  logic [S_TDATA_W-1:0] s_tdata,
  // sensor_sel
  input  logic                 s_tuser,
  input  logic                 s_tlast,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // filtered_distance, gated_sigma, gated_status, targets_out
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic                 m_tlast
);

  item_t   item;
  op_t     push_op;
  op_t     head;
  logic    push;
  logic    pop;
  logic    full;
  logic    not_empty;
  logic    clearing;
  result_t res;

  always_comb begin
    item.sensor_sel    = s_tuser;
    item.zone          = s_tdata[5:0];
    item.target_slot   = s_tdata[7:6];
    item.targets_found = s_tdata[10:8];
    item.status_code   = s_tdata[18:11];
    item.range_mm      = s_tdata[34:19];
    item.sigma_mm      = s_tdata[50:35];
    item.frame_last    = s_tlast;
  end

  tzmf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .item       (item),
    .queue_full (full),
    .clearing   (clearing),
    .push       (push),
    .op         (push_op)
  );

  tzmf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_op   (push_op),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  tzmf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (not_empty),
    .q_head      (head),
    .pop         (pop),
    .clearing    (clearing),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .res         (res)
  );

  assign m_tdata = {5'd0, res.targets_out, res.gated_status, res.gated_sigma,
                    res.filtered_distance};
  assign m_tlast = res.last_of_frame;

endmodule

[rtl/core/tzmf_front.sv]
// front end: gates each slot, builds the history row address and tracks ring position
// uses tzmf_pkg
`timescale 1ns / 1ps

module tzmf_front
  import tzmf_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t item,
  input  logic  queue_full,
  input  logic  clearing,
  output logic  push,
  output op_t   op
);

  logic [1:0]          ring [SENSOR_COUNT];
  logic                sensor_ok;
  logic                zone_ok;
  logic                slot_ok;
  logic                gate_pass;
  logic [SENSOR_W-1:0] idx;
  logic [1:0]          pos;
  logic [1:0]          pos_next;

  assign sensor_ok = 32'(item.sensor_sel) < SENSOR_COUNT;
  assign zone_ok   = 32'(item.zone) < ZONE_COUNT;
  assign slot_ok   = 32'(item.target_slot) < TARGETS_PER_ZONE;

  assign gate_pass = (3'(item.target_slot) < item.targets_found)
                  && (item.status_code == STATUS_RANGE_OK
                      || item.status_code == STATUS_RANGE_WIDE);

  assign idx = sensor_ok ? SENSOR_W'(item.sensor_sel) : '0;

  always_comb begin
    pos = ring[idx];
    if (pos >= 2'(HIST_DEPTH)) begin
      pos = '0;
    end
    pos_next = (pos == 2'(HIST_DEPTH - 1)) ? '0 : pos + 2'd1;
  end

  assign in_ready = !queue_full && !clearing;
  assign push     = in_valid && in_ready;

  always_comb begin
    op.in_range = sensor_ok && zone_ok && slot_ok;
    op.row      = ROW_W'(32'(item.sensor_sel) * SLOTS_PER_SENSOR
                       + 32'(item.zone) * TARGETS_PER_ZONE
                       + 32'(item.target_slot));
    op.col      = pos;
    op.wval     = gate_pass ? item.range_mm : '0;
    op.sigma    = gate_pass ? item.sigma_mm : '0;
    op.status   = gate_pass ? item.status_code : '0;
    op.found    = item.targets_found;
    op.last     = item.frame_last;
  end

  // the last slot of a frame moves that sensor's ring column on
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < int'(SENSOR_COUNT); i++) begin
        ring[i] <= '0;
      end
    end else if (push && sensor_ok && item.frame_last) begin
      ring[idx] <= pos_next;
    end
  end

endmodule

[rtl/core/tzmf_queue.sv]
// short request queue between the front end and the history back end
// uses tzmf_pkg
`timescale 1ns / 1ps

module tzmf_queue
  import tzmf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output op_t  head
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  op_t              entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = count == CNT_W'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("request pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !not_empty))
    else $error("request popped from an empty queue");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count lost a push");

endmodule

[rtl/core/tzmf_back.sv]
// back end: history row memory, read-modify-write with forwarding, median and output register
// uses tzmf_pkg; clears the history memory after reset
`timescale 1ns / 1ps

module tzmf_back
  import tzmf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    q_not_empty,
  input  op_t     q_head,
  output logic    pop,
  output logic    clearing,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t res
);

  typedef logic [HIST_DEPTH-1:0][15:0] row_t;

  row_t             mem [ROWS];
  row_t             rd_data;
  logic [ROW_W-1:0] clear_cnt;

  logic             s1_v;
  op_t              s1_op;
  logic             s1_adv;
  logic             s1_load;
  logic             out_free;

  logic             wr_valid_q;
  logic [ROW_W-1:0] wr_row_q;
  row_t             wr_data_q;

  row_t             cur_row;
  row_t             new_row;
  logic signed [15:0] med;

  logic             mem_we;
  logic [ROW_W-1:0] mem_waddr;
  row_t             mem_wdata;

  function automatic logic signed [15:0] middle3(input logic signed [15:0] a,
                                                 input logic signed [15:0] b,
                                                 input logic signed [15:0] c);
    logic signed [15:0] m;
    if (a > b) begin
      if (b > c) m = b;
      else       m = (a > c) ? c : a;
    end else begin
      if (a > c) m = a;
      else       m = (b > c) ? c : b;
    end
    return m;
  endfunction

  assign out_free = !out_valid || out_ready;
  assign s1_adv   = s1_v && out_free;
  assign s1_load  = q_not_empty && !clearing && (!s1_v || s1_adv);
  assign pop      = s1_load;

  // the previous write lands in the same cycle as this row's read, so forward it
  always_comb begin
    cur_row = (wr_valid_q && wr_row_q == s1_op.row) ? wr_data_q : rd_data;
    new_row = cur_row;
    new_row[s1_op.col] = s1_op.wval;
    med = middle3(new_row[0], new_row[1], new_row[2]);
  end

  assign mem_we    = clearing || (s1_adv && s1_op.in_range);
  assign mem_waddr = clearing ? clear_cnt : s1_op.row;
  assign mem_wdata = clearing ? '0 : new_row;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (s1_load) begin
      rd_data <= mem[q_head.row];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_op <= q_head;
    end
    if (s1_adv && s1_op.in_range) begin
      wr_row_q  <= s1_op.row;
      wr_data_q <= new_row;
    end
    if (s1_adv) begin
      res.filtered_distance <= s1_op.in_range ? med : '0;
      res.gated_sigma       <= s1_op.sigma;
      res.gated_status      <= s1_op.status;
      res.targets_out       <= s1_op.found;
      res.last_of_frame     <= s1_op.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_cnt  <= '0;
      s1_v       <= 1'b0;
      out_valid  <= 1'b0;
      wr_valid_q <= 1'b0;
    end else begin
      if (clearing) begin
        clear_cnt <= clear_cnt + 1'b1;
        if (clear_cnt == ROW_W'(ROWS - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (s1_load) begin
        s1_v <= 1'b1;
      end else if (s1_adv) begin
        s1_v <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (s1_adv && s1_op.in_range) begin
        wr_valid_q <= 1'b1;
      end
    end
  end

  a_no_load_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s1_load && !s1_v && !out_valid)
    else $error("request taken during the history clearing pass");
  a_stage_to_output: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> out_valid)
    else $error("advanced request did not reach the output register");
  a_stall_holds_stage: assert property (@(posedge clk) disable iff (rst)
    s1_v && !out_free |=> s1_v)
    else $error("stalled request dropped from the write stage");

endmodule

[dv/tzmf_checker.sv]
// request/result checker for the zone-gated median filter: keeps its own copy of the
// slot history and ring columns, predicts each result and compares it on the output side
// depends on tzmf_pkg
`timescale 1ns / 1ps

module tzmf_checker
  import tzmf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic                 s_tuser,
  input  logic                 s_tlast,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [M_TDATA_W-1:0] m_tdata,
  input  logic                 m_tlast,
  output int                   fail_count,
  output int                   pending_count,
  output int                   results_checked
);

  logic [15:0] history [SENSOR_COUNT][ZONE_COUNT][TARGETS_PER_ZONE][HIST_DEPTH];
  logic [1:0]  column [SENSOR_COUNT];
  result_t     filtered_q [$];

  function automatic logic signed [15:0] median3(input logic signed [15:0] a,
                                                 input logic signed [15:0] b,
                                                 input logic signed [15:0] c);
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return (c < lo) ? lo : ((c > hi) ? hi : c);
  endfunction

  // read-modify-write of one slot's history, then the median over its three frames
  function automatic result_t filter_slot(input item_t req);
    result_t     r;
    logic        valid;
    int unsigned s;
    int unsigned z;
    int unsigned t;
    int unsigned pos;
    valid = (req.target_slot < req.targets_found) &&
            (req.status_code == STATUS_RANGE_OK || req.status_code == STATUS_RANGE_WIDE);
    s = req.sensor_sel;
    z = req.zone;
    t = req.target_slot;
    r.filtered_distance = '0;
    r.gated_sigma       = valid ? req.sigma_mm : 16'd0;
    r.gated_status      = valid ? req.status_code : 8'd0;
    r.targets_out       = req.targets_found;
    r.last_of_frame     = req.frame_last;
    if (s < SENSOR_COUNT) begin
      pos = column[s];
      if (pos >= HIST_DEPTH) pos = 0;
      if (z < ZONE_COUNT && t < TARGETS_PER_ZONE) begin
        history[s][z][t][pos] = valid ? req.range_mm : 16'd0;
        r.filtered_distance = median3(history[s][z][t][0], history[s][z][t][1],
                                      history[s][z][t][2]);
      end
      // frame end moves the sensor's column on, even for an out-of-range slot
      if (req.frame_last) column[s] = (pos + 1 == HIST_DEPTH) ? 2'd0 : 2'(pos + 1);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    item_t   req;
    result_t want;
    result_t got;
    if (rst) begin
      foreach (history[s, z, t, d]) history[s][z][t][d] = '0;
      foreach (column[s]) column[s] = '0;
      filtered_q.delete();
      fail_count      = 0;
      results_checked = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.filtered_distance = m_tdata[15:0];
        got.gated_sigma       = m_tdata[31:16];
        got.gated_status      = m_tdata[39:32];
        got.targets_out       = m_tdata[42:40];
        got.last_of_frame     = m_tlast;
        if (filtered_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result with no request outstanding: dist %0d sigma %0d",
                     $time, got.filtered_distance, got.gated_sigma);
        end else begin
          want = filtered_q.pop_front();
          results_checked++;
          if (got.filtered_distance !== want.filtered_distance ||
              got.gated_sigma !== want.gated_sigma ||
              got.gated_status !== want.gated_status ||
              got.targets_out !== want.targets_out ||
              got.last_of_frame !== want.last_of_frame) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: mismatch, expected dist %0d sigma %0d status %0d count %0d last %0d",
                       $time, want.filtered_distance, want.gated_sigma, want.gated_status,
                       want.targets_out, want.last_of_frame);
              $display("%0t:           got      dist %0d sigma %0d status %0d count %0d last %0d",
                       $time, got.filtered_distance, got.gated_sigma, got.gated_status,
                       got.targets_out, got.last_of_frame);
            end
          end
        end
      end
      if (s_tvalid && s_tready) begin
        req.sensor_sel    = s_tuser;
        req.zone          = s_tdata[5:0];
        req.target_slot   = s_tdata[7:6];
        req.targets_found = s_tdata[10:8];
        req.status_code   = s_tdata[18:11];
        req.range_mm      = s_tdata[34:19];
        req.sigma_mm      = s_tdata[50:35];
        req.frame_last    = s_tlast;
        filtered_q.push_back(filter_slot(req));
      end
    end
    pending_count = filtered_q.size();
  end

endmodule

[dv/tb.sv]
// top of the zone-gated median filter regression: clock, reset, request stimulus,
// output back-pressure and the verdict
// depends on tzmf_pkg, tzmf_checker and the tof_zone_gated_median_filter rtl
`timescale 1ns / 1ps

module tb
  import tzmf_pkg::*;
();

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 200;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic                 s_tuser;
  logic                 s_tlast;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tlast;

  int fail_count;
  int pending_count;
  int results_checked;
  int sent_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;

  item_t directed_q [$];

  always #5 clk = ~clk;

  tof_zone_gated_median_filter u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  tzmf_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .s_tlast         (s_tlast),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tlast         (m_tlast),
    .fail_count      (fail_count),
    .pending_count   (pending_count),
    .results_checked (results_checked)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending_count);
      $display("tof_zone_gated_median_filter regression: fail");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off when asked for
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) begin
          m_tready <= 1'b0;
          @(negedge clk);
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic item_t slot_item(input int s, input int z, input int t, input int f,
                                      input int st, input int d, input int sg, input int l);
    item_t it;
    it.sensor_sel    = s[0];
    it.zone          = z[5:0];
    it.target_slot   = t[1:0];
    it.targets_found = f[2:0];
    it.status_code   = st[7:0];
    it.range_mm      = d[15:0];
    it.sigma_mm      = sg[15:0];
    it.frame_last    = l[0];
    return it;
  endfunction

  // most requests land on a few zones so each slot's history sees several frames
  function automatic item_t random_slot(input logic sensor, input logic last);
    item_t it;
    int    pick;
    it.sensor_sel    = sensor;
    it.zone          = ($urandom_range(99) < 80) ? 6'($urandom_range(3)) :
                                                   6'($urandom_range(63));
    it.target_slot   = 2'($urandom_range(3));
    it.targets_found = ($urandom_range(99) < 85) ? 3'($urandom_range(4)) :
                                                   3'($urandom_range(7));
    pick = $urandom_range(9);
    it.status_code   = (pick < 4) ? STATUS_RANGE_OK :
                       (pick < 7) ? STATUS_RANGE_WIDE : 8'($urandom_range(255));
    pick = $urandom_range(19);
    it.range_mm      = (pick == 0) ? 16'h7fff : (pick == 1) ? 16'h8000 :
                       (pick < 10) ? 16'($urandom_range(4000)) : 16'($urandom);
    it.sigma_mm      = 16'($urandom);
    it.frame_last    = last;
    return it;
  endfunction

  task automatic offer(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.sensor_sel;
    s_tlast  <= it.frame_last;
    s_tdata  <= {5'd0, it.sigma_mm, it.range_mm, it.status_code, it.targets_found,
                 it.target_slot, it.zone};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    sent_count++;
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
  endtask

  // a frame from one sensor; now and then a stray or missing frame end
  task automatic send_frame();
    logic sensor;
    int   n;
    logic last;
    sensor = 1'($urandom_range(1));
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      last = (i == n - 1);
      if ($urandom_range(99) < 8) last = 1'($urandom_range(1));
      offer(random_slot(sensor, last));
    end
  endtask

  task automatic run_phase(input int n_items, input int send_pct, input int recv_pct);
    int start;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start = sent_count;
    while (sent_count - start < n_items) send_frame();
    wait_for_results();
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = 1'b0;
    s_tlast  = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // field extremes and every way a slot can fail the gate
    directed_q.push_back(slot_item(0, 0, 0, 1, 5, 1234, 0, 0));
    directed_q.push_back(slot_item(0, 63, 3, 4, 9, 32767, 65535, 0));
    directed_q.push_back(slot_item(0, 63, 2, 2, 9, -1, 77, 0));
    directed_q.push_back(slot_item(0, 1, 0, 0, 5, 500, 12, 0));
    directed_q.push_back(slot_item(0, 2, 0, 7, 5, -32768, 3, 0));
    directed_q.push_back(slot_item(0, 3, 0, 4, 0, 900, 5, 0));
    directed_q.push_back(slot_item(0, 3, 1, 4, 255, 901, 6, 0));
    directed_q.push_back(slot_item(0, 3, 2, 4, 4, 902, 7, 0));
    directed_q.push_back(slot_item(0, 3, 3, 4, 6, 903, 8, 1));
    // three frames on one slot so the median sees all three columns
    directed_q.push_back(slot_item(0, 63, 3, 4, 5, -32768, 1, 1));
    directed_q.push_back(slot_item(0, 63, 3, 4, 9, 100, 2, 1));
    directed_q.push_back(slot_item(0, 63, 3, 4, 9, -100, 2, 1));
    // second sensor, its own ring, count above four, invalid write of zero
    directed_q.push_back(slot_item(1, 63, 3, 5, 5, 777, 40, 0));
    directed_q.push_back(slot_item(1, 0, 0, 4, 9, -5, 41, 1));
    directed_q.push_back(slot_item(1, 63, 3, 4, 5, -300, 42, 1));
    directed_q.push_back(slot_item(1, 63, 3, 4, 8, 12345, 43, 1));
    directed_q.push_back(slot_item(1, 0, 1, 3, 5, 16'h55aa, 16'haa55, 0));
    directed_q.push_back(slot_item(1, 42, 2, 6, 9, 16'h2a55, 16'h55aa, 1));
    send_idle_pct = 6;
    recv_idle_pct = 74;
    foreach (directed_q[i]) offer(directed_q[i]);
    wait_for_results();

    run_phase(280, 6, 74);
    run_phase(280, 74, 6);
    // output held off while requests keep coming, so the input backs up
    hold_req = 1'b1;
    run_phase(290, 0, 0);

    repeat (10) @(posedge clk);
    $display("sent %0d slot requests from both sensors, %0d filtered results checked",
             sent_count, results_checked);
    $display("covered gate extremes, three-frame medians, both idling mixes and a long hold-off");
    if (fail_count == 0 && pending_count == 0) begin
      $display("tof_zone_gated_median_filter regression: pass");
    end else begin
      $display("tof_zone_gated_median_filter regression: fail");
    end
    $finish;
  end

endmodule
